// File: rtl/lfu_pkg.sv
// Package for the LFU cache table: sizes, payload structs, state codes.
// Used by every module in rtl/.
package lfu_pkg;
   localparam int ENTRIES    = 16;
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_BITS   = $clog2(ENTRIES + 1);
   localparam int COUNT_BITS = 16;
   localparam int CAP_BITS   = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(ENTRIES);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic {OP_GET = 1'b0, OP_PUT = 1'b1} op_type;

   typedef struct packed {
      logic               op;
      logic signed [31:0] lookup_key;
      logic signed [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
   } rsp_type;

   // Classified command handed from the front end to the back end.
   typedef struct packed {
      logic                op;
      logic                found;
      logic [IDX_BITS-1:0] slot;
      logic [31:0]         key;
      logic [31:0]         value;
   } cmd_type;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_APPLY} back_state_type;
endpackage

// File: rtl/lfu_front.sv
// Front end: holds the table of keys and valid bits, matches a request's key.
// Depends on lfu_pkg; the back end drives all table writes through key_* and valid_in.
module lfu_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  lfu_pkg::req_type                 in_req,
   output logic                             out_valid,
   output lfu_pkg::cmd_type                 out_cmd,
   input  logic                             key_we,
   input  logic [lfu_pkg::IDX_BITS-1:0]     key_idx,
   input  logic [31:0]                      key_data,
   input  logic [lfu_pkg::ENTRIES-1:0]      valid_in,
   output logic [lfu_pkg::ENTRIES-1:0]      valid_out
);
   logic [31:0]                  key_ff [lfu_pkg::ENTRIES];
   logic [lfu_pkg::ENTRIES-1:0]  valid_ff;
   logic                         found;
   logic [lfu_pkg::IDX_BITS-1:0] slot;

   always_comb begin
      found = 1'b0;
      slot  = '0;
      for (int i = lfu_pkg::ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == in_req.lookup_key) begin
            found = 1'b1;
            slot  = lfu_pkg::IDX_BITS'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_ff[key_idx] <= key_data;
      end
      out_cmd <= '{op: in_req.op, found: found, slot: slot,
                   key: in_req.lookup_key, value: in_req.write_value};
      if (reset) begin
         valid_ff  <= '0;
         out_valid <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         out_valid <= in_valid;
      end
   end

   assign valid_out = valid_ff;
endmodule

// File: rtl/lfu_back.sv
// Back end: values, use counts and recency ranks; scans for the victim.
// Depends on lfu_pkg; reads valid bits from and writes keys to lfu_front.
module lfu_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  lfu_pkg::cmd_type             cmd,
   input  logic [lfu_pkg::CAP_BITS-1:0] capacity,
   input  logic [lfu_pkg::ENTRIES-1:0]  valid_cur,
   output logic [lfu_pkg::ENTRIES-1:0]  valid_nxt,
   output logic                         key_we,
   output logic [lfu_pkg::IDX_BITS-1:0] key_idx,
   output logic [31:0]                  key_data,
   output logic                         busy,
   output logic                         rsp_strobe,
   output lfu_pkg::rsp_type             rsp
);
   localparam int IB = lfu_pkg::IDX_BITS;
   localparam int CB = lfu_pkg::COUNT_BITS;
   localparam int OB = lfu_pkg::OCC_BITS;

   logic [31:0]   value_ff [lfu_pkg::ENTRIES];
   logic [CB-1:0] count_ff [lfu_pkg::ENTRIES];
   logic [IB-1:0] rank_ff  [lfu_pkg::ENTRIES];
   logic [OB-1:0] occ_ff, occ_in;
   lfu_pkg::back_state_type state_ff, state_in;
   lfu_pkg::cmd_type cmd_ff, cmd_in;
   logic [IB-1:0] scan_ff, scan_in, vic_ff, vic_in;
   logic          vic_ok_ff, vic_ok_in;
   logic [OB-1:0] cap_eff;
   logic          do_evict;
   logic [IB-1:0] free_slot;
   logic          better;

   always_comb begin
      if (capacity == '0) cap_eff = OB'(1);
      else if (32'(capacity) > lfu_pkg::ENTRIES) cap_eff = OB'(lfu_pkg::ENTRIES);
      else cap_eff = OB'(capacity);
   end

   assign do_evict = (occ_ff >= cap_eff) && vic_ok_ff;

   always_comb begin
      logic [lfu_pkg::ENTRIES-1:0] vmask;
      vmask = valid_cur;
      if (do_evict) vmask[vic_ff] = 1'b0;
      free_slot = '0;
      for (int i = lfu_pkg::ENTRIES - 1; i >= 0; i--) begin
         if (!vmask[i]) free_slot = IB'(i);
      end
   end

   always_comb begin
      better = 1'b0;
      if (valid_cur[scan_ff]) begin
         better = !vic_ok_ff || count_ff[scan_ff] < count_ff[vic_ff] ||
                  (count_ff[scan_ff] == count_ff[vic_ff] &&
                   rank_ff[scan_ff] > rank_ff[vic_ff]);
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      scan_in    = scan_ff;
      vic_in     = vic_ff;
      vic_ok_in  = vic_ok_ff;
      occ_in     = occ_ff;
      valid_nxt  = valid_cur;
      key_we     = 1'b0;
      key_idx    = free_slot;
      key_data   = cmd_ff.key;
      rsp_strobe = 1'b0;
      rsp        = '{hit: cmd_ff.found, read_value: '0};
      busy       = (state_ff != lfu_pkg::ST_IDLE);
      unique case (state_ff)
         lfu_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in    = cmd;
               scan_in   = '0;
               vic_ok_in = 1'b0;
               busy      = 1'b1;
               if (cmd.op == lfu_pkg::OP_PUT && !cmd.found) state_in = lfu_pkg::ST_SCAN;
               else state_in = lfu_pkg::ST_APPLY;
            end
         end
         lfu_pkg::ST_SCAN: begin
            if (better) begin
               vic_in    = scan_ff;
               vic_ok_in = 1'b1;
            end
            scan_in = scan_ff + IB'(1);
            if (32'(scan_ff) == lfu_pkg::ENTRIES - 1) state_in = lfu_pkg::ST_APPLY;
         end
         lfu_pkg::ST_APPLY: begin
            rsp_strobe = 1'b1;
            state_in   = lfu_pkg::ST_IDLE;
            if (cmd_ff.op == lfu_pkg::OP_GET) begin
               rsp.read_value = cmd_ff.found ? value_ff[cmd_ff.slot] : '1;
            end else if (!cmd_ff.found) begin
               if (do_evict) valid_nxt[vic_ff] = 1'b0;
               if (!(&valid_nxt)) begin
                  valid_nxt[free_slot] = 1'b1;
                  key_we = 1'b1;
                  occ_in = occ_ff - OB'(do_evict) + OB'(1);
               end else begin
                  occ_in = occ_ff - OB'(do_evict);
               end
            end
         end
         default: state_in = lfu_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == lfu_pkg::ST_APPLY) begin
         if (cmd_ff.found) begin
            for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
               if (valid_cur[i] && IB'(i) != cmd_ff.slot &&
                   rank_ff[i] < rank_ff[cmd_ff.slot]) rank_ff[i] <= rank_ff[i] + IB'(1);
            end
            rank_ff[cmd_ff.slot] <= '0;
            if (count_ff[cmd_ff.slot] != lfu_pkg::COUNT_MAX)
               count_ff[cmd_ff.slot] <= count_ff[cmd_ff.slot] + CB'(1);
            if (cmd_ff.op == lfu_pkg::OP_PUT) value_ff[cmd_ff.slot] <= cmd_ff.value;
         end else if (cmd_ff.op == lfu_pkg::OP_PUT) begin
            // Evicted ranks close the gap, then the new entry pushes all back.
            for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
               if (valid_nxt[i] && IB'(i) != free_slot)
                  rank_ff[i] <= rank_ff[i]
                     - IB'(do_evict && rank_ff[i] > rank_ff[vic_ff]) + IB'(1);
            end
            if (key_we) begin
               rank_ff[free_slot]  <= '0;
               count_ff[free_slot] <= CB'(1);
               value_ff[free_slot] <= cmd_ff.value;
            end
         end
      end
      cmd_ff    <= cmd_in;
      scan_ff   <= scan_in;
      vic_ff    <= vic_in;
      vic_ok_ff <= vic_ok_in;
      if (reset) begin
         state_ff <= lfu_pkg::ST_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
   end
endmodule

// File: rtl/lfu_cache_table.sv
// LFU cache table top level: front end (key match) and back end.
// A get or an update is registered in the front end, then answered in the APPLY state;
// a new-key put first runs the one-entry-per-cycle victim scan over all ENTRIES slots.
// busy holds through the response cycle, so no new request is taken before the answer.
// Synchronous active-high reset clears valid bits, occupancy and control; capacity resets
// to ENTRIES. Results cannot be stalled: each shows on rsp_strobe for one cycle.
module lfu_cache_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  lfu_pkg::req_type             req_payload,
   output logic                         rsp_strobe,
   output lfu_pkg::rsp_type             rsp_payload,
   input  logic                         csr_we,
   input  logic [lfu_pkg::CAP_BITS-1:0] csr_wdata
);
   logic [lfu_pkg::CAP_BITS-1:0] cap_ff;
   logic                         busy_ff;
   logic                         accept;
   logic                         cmd_valid;
   lfu_pkg::cmd_type             cmd;
   logic [lfu_pkg::ENTRIES-1:0]  valid_cur, valid_nxt;
   logic                         key_we;
   logic [lfu_pkg::IDX_BITS-1:0] key_idx;
   logic [31:0]                  key_data;
   logic                         back_busy;

   // The request is held busy from acceptance until its response leaves.
   assign accept = start && !busy;
   assign busy   = busy_ff || cmd_valid || back_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= lfu_pkg::CAP_RESET;
         busy_ff <= 1'b0;
      end else begin
         if (csr_we) cap_ff <= csr_wdata;
         busy_ff <= accept;
      end
   end

   lfu_front u_front (
      .clock, .reset,
      .in_valid(accept), .in_req(req_payload),
      .out_valid(cmd_valid), .out_cmd(cmd),
      .key_we, .key_idx, .key_data,
      .valid_in(valid_nxt), .valid_out(valid_cur)
   );

   lfu_back u_back (
      .clock, .reset,
      .cmd_valid, .cmd, .capacity(cap_ff),
      .valid_cur, .valid_nxt,
      .key_we, .key_idx, .key_data,
      .busy(back_busy), .rsp_strobe, .rsp(rsp_payload)
   );
endmodule

// File: rtl/lfu_checker.sv
// Port-level checker for lfu_cache_table, attached by bind below.
// Depends on lfu_pkg.
module lfu_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input lfu_pkg::rsp_type rsp_payload
);
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after request");
   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_strobe) else $error("response while idle");
   a_busy_drops: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy) else $error("busy held after response");
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.hit == 1'b0 && rsp_payload.read_value != '0 |->
      rsp_payload.read_value == '1) else $error("bad miss value");
endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
   .clock, .reset, .start, .busy, .rsp_strobe, .rsp_payload
);

// File: tb/sv/lfu_table_checker.sv
// Checker for the LFU cache table: tracks requests and responses, predicts each response
// and compares it field by field. Depends on lfu_pkg for sizes and payload types.
`timescale 1ns / 100ps
module lfu_table_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  lfu_pkg::req_type             req_payload,
   input  logic                         rsp_strobe,
   input  lfu_pkg::rsp_type             rsp_payload,
   input  logic                         csr_we,
   input  logic [lfu_pkg::CAP_BITS-1:0] csr_wdata,
   output int                           fail_count,
   output int                           pending_count
);
   import lfu_pkg::*;

   logic                  slot_valid [ENTRIES];
   logic [31:0]           slot_key   [ENTRIES];
   logic [31:0]           slot_value [ENTRIES];
   logic [COUNT_BITS-1:0] slot_uses  [ENTRIES];
   int                    slot_age   [ENTRIES];
   int                    occupancy;
   logic [CAP_BITS-1:0]   cap_reg;
   rsp_type               expected_rsps [$];

   // Marks a slot as just used; only entries more recent than it age by one.
   function automatic void mark_used(int s);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
      slot_age[s] = 0;
      if (slot_uses[s] != COUNT_MAX) slot_uses[s]++;
   endfunction

   function automatic void evict_victim();
      int v;
      v = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!slot_valid[i]) continue;
         if (v < 0 || slot_uses[i] < slot_uses[v] ||
             (slot_uses[i] == slot_uses[v] && slot_age[i] > slot_age[v])) v = i;
      end
      if (v < 0) return;
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i] && slot_age[i] > slot_age[v]) slot_age[i]--;
      slot_valid[v] = 1'b0;
      occupancy--;
   endfunction

   function automatic rsp_type predict_access(req_type r);
      rsp_type o;
      int      found, lim, free_slot;
      found = -1;
      lim = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg));
      for (int i = 0; i < ENTRIES; i++)
         if (found < 0 && slot_valid[i] && slot_key[i] == r.lookup_key) found = i;
      o.hit = (found >= 0);
      o.read_value = 32'sd0;
      if (r.op == OP_GET) begin
         if (found >= 0) begin
            mark_used(found);
            o.read_value = slot_value[found];
         end else begin
            o.read_value = -32'sd1;
         end
      end else if (found >= 0) begin
         mark_used(found);
         slot_value[found] = r.write_value;
      end else begin
         if (occupancy >= lim) evict_victim();
         free_slot = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (free_slot < 0 && !slot_valid[i]) free_slot = i;
         if (free_slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++) if (slot_valid[i]) slot_age[i]++;
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot]   = r.lookup_key;
            slot_value[free_slot] = r.write_value;
            slot_uses[free_slot]  = COUNT_BITS'(1);
            slot_age[free_slot]   = 0;
            occupancy++;
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   initial fail_count = 0;
   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
         occupancy = 0;
         cap_reg = CAP_RESET;
         expected_rsps.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_payload.hit !== e.hit)
                  report_mismatch($sformatf("hit got %b want %b", rsp_payload.hit, e.hit));
               if (rsp_payload.read_value !== e.read_value)
                  report_mismatch($sformatf("read_value got %0d want %0d",
                                            rsp_payload.read_value, e.read_value));
            end
         end
         if (start && !busy) expected_rsps.push_back(predict_access(req_payload));
         if (csr_we) cap_reg = csr_wdata;
      end
   end
endmodule

// File: tb/sv/tb_lfu_cache_table.sv
// Testbench top for the LFU cache table: clock, reset, request stimulus and verdict.
// Depends on lfu_pkg, the lfu_cache_table RTL and lfu_table_checker.
`timescale 1ns / 100ps
module tb_lfu_cache_table;
   import lfu_pkg::*;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_payload;
   logic                rsp_strobe;
   rsp_type             rsp_payload;
   logic                csr_we;
   logic [CAP_BITS-1:0] csr_wdata;
   int                  fail_count;
   int                  pending_count;
   int                  gap_pct;
   int                  requests_sent;
   int                  stall_cycles;
   logic [31:0]         key_pool [8];

   // A new-key put is the slowest request, so the DRAIN_CYCLES idle window
   // is far beyond what any correct response needs.
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 5000;

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   lfu_cache_table u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   lfu_table_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // The watchdog counts cycles in which neither a request nor a response moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d responses outstanding", pending_count);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Sends one request. The sender first idles at random for gap_pct percent of the
   // cycles, then holds start until the block accepts the request. start may stay high
   // after acceptance; busy is high in the following cycle, so nothing is taken twice.
   task automatic send_request(logic op, logic [31:0] key, logic [31:0] value);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_payload.op <= op;
      req_payload.lookup_key <= key;
      req_payload.write_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      requests_sent++;
   endtask

   // Waits until every response has come, then lets the back end settle before any
   // capacity write.
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_BITS-1:0] cap);
      drain_responses();
      csr_we <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly keys from a small pool so that hits, updates and evictions are common;
   // the rest are fully random keys.
   function automatic logic [31:0] pick_key();
      if ($urandom_range(9) < 8) return key_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   task automatic random_phase(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(63) == 0) key_pool[$urandom_range(7)] = $urandom;
         send_request(1'($urandom_range(1)), pick_key(), $urandom);
      end
   endtask

   initial begin
      logic [CAP_BITS-1:0] phase_caps [6];
      phase_caps = '{5'd1, 5'd3, 5'd16, 5'd0, 5'd31, 5'd8};
      start = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      gap_pct = 0;
      requests_sent = 0;
      stall_cycles = 0;
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: misses on an empty table, extreme keys and values, update, hit.
      send_request(OP_GET, 32'h8000_0000, 32'h0);
      send_request(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
      send_request(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
      send_request(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
      send_request(OP_PUT, 32'h0, 32'h0);
      send_request(OP_GET, 32'h8000_0000, 32'h1234_5678);
      send_request(OP_PUT, 32'h7fff_ffff, 32'h5555_aaaa);
      send_request(OP_GET, 32'h7fff_ffff, 32'h0);
      send_request(OP_GET, 32'hffff_ffff, 32'h0);
      send_request(OP_GET, 32'h0, 32'hffff_ffff);
      // Capacity lowered below occupancy: each new key evicts one entry, so the table does not shrink,
      // and the victim choice breaks equal counts by age.
      write_capacity(5'd2);
      send_request(OP_PUT, 32'h0000_0011, 32'haaaa_5555);
      send_request(OP_PUT, 32'h0000_0022, 32'h1);
      send_request(OP_GET, 32'h0000_0011, 32'h0);
      send_request(OP_PUT, 32'h0000_0033, 32'h2);
      send_request(OP_GET, 32'h0000_0022, 32'h0);
      send_request(OP_GET, 32'h0000_0033, 32'h0);
      // Capacity zero behaves as one entry.
      write_capacity(5'd0);
      send_request(OP_PUT, 32'h0000_0044, 32'h3);
      send_request(OP_GET, 32'h0000_0044, 32'h0);
      send_request(OP_PUT, 32'h0000_0055, 32'h4);
      send_request(OP_GET, 32'h0000_0044, 32'h0);

      // Random phases across capacity settings with three idling profiles.
      for (int p = 0; p < 6; p++) begin
         write_capacity(phase_caps[p]);
         gap_pct = (p < 2) ? 23 : ((p < 4) ? 83 : 0);
         random_phase((p < 2 || p >= 4) ? 190 : 90);
         if (p == 2) drain_responses();
      end

      drain_responses();
      $display("Sent %0d get/put requests over capacities 0, 1, 2, 3, 8, 16 and 31,",
               requests_sent);
      $display("with extreme keys, updates, evictions and sender gaps of 0, 23 and 83 percent.");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

// File: filelist.f
rtl/lfu_pkg.sv
rtl/lfu_front.sv
rtl/lfu_back.sv
rtl/lfu_cache_table.sv
rtl/lfu_checker.sv
tb/sv/lfu_table_checker.sv
tb/sv/tb_lfu_cache_table.sv
